### rtl/core/spq_pkg.sv
// spq_pkg: shared types and codes for the stable min priority queue
// used by spq_cell and stable_min_priority_queue; no dependencies
package spq_pkg;

  localparam int TAG_W = 24;
  localparam int PRI_W = 16;

  typedef struct packed {
    logic [TAG_W-1:0]        tag;
    logic signed [PRI_W-1:0] pri;
  } entry_t;

  // command broadcast to every cell in the row
  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t ent;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_RESULT
  } state_t;

  localparam logic FUNC_ENQ = 1'b0;

endpackage

### rtl/core/stable_min_priority_queue.sv
// stable_min_priority_queue: sorted priority queue built as a row of spq_cell slots
// depends on spq_pkg and spq_cell
//
//  channel  | dir | fields (low bit up)
//  s_axis   | in  | func[0] tag[24:1] priority_req[40:25], zero pad to 48
//  m_axis   | out | status out_tag out_priority occupancy is_empty head_tag
//           |     | head_priority tail_tag tail_priority, zero pad to 152
//
// when an item is taken, every cell compares and shifts at that same edge
// the result word is offered from the next cycle on; a new item is taken only
// after the result word is taken
// a stall on m_tready holds the result and keeps s_tready low
// rst empties the queue and drops any pending result
module stable_min_priority_queue #(
  parameter int DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [47:0]  s_tdata,   // func, tag, priority_req
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [151:0] m_tdata    // status, out_tag, out_priority, occupancy, is_empty,
                                  // head_tag, head_priority, tail_tag, tail_priority
);

  localparam int CW = $clog2(DEPTH + 1);

  spq_pkg::state_t  state, state_next;
  logic [CW-1:0]    count;
  spq_pkg::status_t status;
  spq_pkg::entry_t  out_ent;

  logic              in_func;
  spq_pkg::entry_t   in_ent;
  logic              accept, full, empty;
  spq_pkg::cmd_t     cmd;
  logic [DEPTH:0]    occ;
  logic [DEPTH:0]    keep_chain;
  spq_pkg::entry_t   cell_ent [DEPTH];
  logic [DEPTH-1:0]  tail_sel;
  spq_pkg::entry_t   head_ent, tail_ent;

  assign in_func    = s_tdata[0];
  assign in_ent.tag = s_tdata[24:1];
  assign in_ent.pri = s_tdata[40:25];

  assign accept = s_tvalid && s_tready;
  assign full   = (count == CW'(DEPTH));
  assign empty  = (count == '0);

  assign cmd.enq = accept && (in_func == spq_pkg::FUNC_ENQ) && !full;
  assign cmd.deq = accept && (in_func != spq_pkg::FUNC_ENQ) && !empty;
  assign cmd.ent = in_ent;

  assign keep_chain[0] = 1'b1;
  assign occ[DEPTH]    = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_row
    spq_pkg::entry_t prev_e, next_e;

    assign occ[i]      = (count > CW'(i));
    assign tail_sel[i] = occ[i] && !occ[i+1];

    if (i == 0) begin : g_first
      assign prev_e = cmd.ent;
    end else begin : g_mid
      assign prev_e = cell_ent[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_e = '0;
    end else begin : g_inner
      assign next_e = cell_ent[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .occ       (occ[i]),
      .prev_keep (keep_chain[i]),
      .prev_ent  (prev_e),
      .next_ent  (next_e),
      .keep      (keep_chain[i+1]),
      .ent       (cell_ent[i])
    );
  end

  // one-hot pick of the rear slot
  always_comb begin
    tail_ent = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail_ent = tail_ent | (tail_sel[i] ? cell_ent[i] : '0);
    end
  end

  assign head_ent = empty ? '0 : cell_ent[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spq_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (cmd.enq) begin
        count <= count + CW'(1);
      end else if (cmd.deq) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_ent <= '0;
      status  <= spq_pkg::ST_OK;
      if (in_func == spq_pkg::FUNC_ENQ) begin
        if (full) begin
          status <= spq_pkg::ST_OVERFLOW;
        end
      end else if (empty) begin
        status <= spq_pkg::ST_UNDERFLOW;
      end else begin
        out_ent <= cell_ent[0];
      end
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    m_tvalid   = 1'b0;
    case (state)
      spq_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = spq_pkg::S_RESULT;
        end
      end
      spq_pkg::S_RESULT: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          state_next = spq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = spq_pkg::S_IDLE;
      end
    endcase
  end

  assign m_tdata = {24'd0,
                    tail_ent.pri, tail_ent.tag,
                    head_ent.pri, head_ent.tag,
                    empty, 5'(count),
                    out_ent.pri, out_ent.tag,
                    status};

endmodule

### rtl/core/spq_cell.sv
// spq_cell: one slot of the sorted row; holds an entry and trades with neighbors
// depends on spq_pkg
module spq_cell (
  input  logic              clk,
  input  spq_pkg::cmd_t     cmd,
  input  logic              occ,
  input  logic              prev_keep,
  input  spq_pkg::entry_t   prev_ent,
  input  spq_pkg::entry_t   next_ent,
  output logic              keep,
  output spq_pkg::entry_t   ent
);

  // an occupied slot with priority <= new one stays put (keeps fifo order on ties)
  assign keep = occ && (ent.pri <= cmd.ent.pri);

  always_ff @(posedge clk) begin
    if (cmd.enq) begin
      if (!keep && prev_keep) begin
        ent <= cmd.ent;
      end else if (!keep) begin
        ent <= prev_ent;
      end
    end else if (cmd.deq) begin
      ent <= next_ent;
    end
  end

endmodule

### dv/stable_min_priority_queue_tb.sv
// stable_min_priority_queue_tb: self-checking bench for the sorted min priority queue
// keeps a shadow sorted list per accepted word and checks every result word field by field
// depends on spq_pkg and the stable_min_priority_queue rtl
module stable_min_priority_queue_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QDEPTH = 16;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 8;
  localparam logic FUNC_DEQ = ~spq_pkg::FUNC_ENQ;

  typedef struct {
    spq_pkg::status_t                 status;
    logic [spq_pkg::TAG_W-1:0]        out_tag;
    logic signed [spq_pkg::PRI_W-1:0] out_pri;
    logic [4:0]                       occupancy;
    logic                             is_empty;
    logic [spq_pkg::TAG_W-1:0]        head_tag;
    logic signed [spq_pkg::PRI_W-1:0] head_pri;
    logic [spq_pkg::TAG_W-1:0]        tail_tag;
    logic signed [spq_pkg::PRI_W-1:0] tail_pri;
  } queue_result_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [47:0]  s_tdata = '0;    // func, tag, priority_req
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [151:0] m_tdata;         // status, out_tag, out_priority, occupancy, is_empty,
                                 // head_tag, head_priority, tail_tag, tail_priority

  // shadow copy of the sorted entries
  logic [spq_pkg::TAG_W-1:0]        shadow_tag [QDEPTH];
  logic signed [spq_pkg::PRI_W-1:0] shadow_pri [QDEPTH];
  int                               shadow_count = 0;

  queue_result_t pending_results[$];
  int fail_count = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  stable_min_priority_queue #(
    .DEPTH(QDEPTH)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // apply one word to the shadow list and queue the result it must produce
  task automatic compute_queue_step(input logic func, input logic [spq_pkg::TAG_W-1:0] tag,
                                    input logic signed [spq_pkg::PRI_W-1:0] pri);
    queue_result_t r;
    int pos;
    r.status  = spq_pkg::ST_OK;
    r.out_tag = '0;
    r.out_pri = '0;
    if (func == spq_pkg::FUNC_ENQ) begin
      if (shadow_count >= QDEPTH) begin
        r.status = spq_pkg::ST_OVERFLOW;
      end else begin
        // new entry goes behind every entry with priority <= its own
        pos = 0;
        while (pos < shadow_count && shadow_pri[pos] <= pri) pos++;
        for (int i = shadow_count; i > pos; i--) begin
          shadow_tag[i] = shadow_tag[i-1];
          shadow_pri[i] = shadow_pri[i-1];
        end
        shadow_tag[pos] = tag;
        shadow_pri[pos] = pri;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = spq_pkg::ST_UNDERFLOW;
      end else begin
        r.out_tag = shadow_tag[0];
        r.out_pri = shadow_pri[0];
        for (int i = 1; i < shadow_count; i++) begin
          shadow_tag[i-1] = shadow_tag[i];
          shadow_pri[i-1] = shadow_pri[i];
        end
        shadow_count--;
      end
    end
    r.occupancy = shadow_count[4:0];
    r.is_empty  = (shadow_count == 0);
    if (shadow_count > 0) begin
      r.head_tag = shadow_tag[0];
      r.head_pri = shadow_pri[0];
      r.tail_tag = shadow_tag[shadow_count-1];
      r.tail_pri = shadow_pri[shadow_count-1];
    end else begin
      r.head_tag = '0;
      r.head_pri = '0;
      r.tail_tag = '0;
      r.tail_pri = '0;
    end
    pending_results.push_back(r);
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic check_result(input logic [151:0] word);
    queue_result_t want;
    if (pending_results.size() == 0) begin
      $error("result word with nothing expected: 0x%0h", word);
      fail_count++;
    end else begin
      want = pending_results.pop_front();
      check_field("status", 32'(want.status), 32'(word[1:0]));
      check_field("out_tag", 32'(want.out_tag), 32'(word[25:2]));
      check_field("out_priority", 32'(unsigned'(want.out_pri)), 32'(word[41:26]));
      check_field("occupancy", 32'(want.occupancy), 32'(word[46:42]));
      check_field("is_empty", 32'(want.is_empty), 32'(word[47]));
      check_field("head_tag", 32'(want.head_tag), 32'(word[71:48]));
      check_field("head_priority", 32'(unsigned'(want.head_pri)), 32'(word[87:72]));
      check_field("tail_tag", 32'(want.tail_tag), 32'(word[111:88]));
      check_field("tail_priority", 32'(unsigned'(want.tail_pri)), 32'(word[127:112]));
    end
  endtask

  // sample mid-cycle: these values hold at the next rising edge
  always @(negedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) check_result(m_tdata);
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("== FAIL ==");
          $finish;
        end
      end
    end
  end

  // called at a rising edge; returns at the edge that takes the word
  task automatic send_op(input logic func, input logic [spq_pkg::TAG_W-1:0] tag,
                         input logic signed [spq_pkg::PRI_W-1:0] pri);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'b0, pri, tag, func};
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    compute_queue_step(func, tag, pri);
  endtask

  task automatic test_directed_corners();
    send_op(FUNC_DEQ, 24'h000000, 16'sd0);          // dequeue on empty
    send_op(spq_pkg::FUNC_ENQ, 24'h414141, 16'sd0);
    send_op(spq_pkg::FUNC_ENQ, 24'hFFFFFF, 16'sh7FFF);
    send_op(spq_pkg::FUNC_ENQ, 24'h000000, 16'sh8000);
    send_op(spq_pkg::FUNC_ENQ, 24'h414142, 16'sd0);          // tie lands behind the first zero
    send_op(spq_pkg::FUNC_ENQ, 24'h800001, -16'sd1);
    send_op(spq_pkg::FUNC_ENQ, 24'h7FFFFE, 16'sh7FFF);       // tie at the tail
    send_op(spq_pkg::FUNC_ENQ, 24'hAAAAAA, 16'sh8000);       // tie at the head
    send_op(spq_pkg::FUNC_ENQ, 24'h555555, 16'sd1);
    send_op(spq_pkg::FUNC_ENQ, 24'h000010, -16'sd2);
    send_op(spq_pkg::FUNC_ENQ, 24'h000011, 16'sd2);
    send_op(spq_pkg::FUNC_ENQ, 24'h000012, 16'sd0);
    send_op(spq_pkg::FUNC_ENQ, 24'h000013, 16'sh8001);
    send_op(spq_pkg::FUNC_ENQ, 24'h000014, 16'sh7FFE);
    send_op(spq_pkg::FUNC_ENQ, 24'h000015, 16'sd5);
    send_op(spq_pkg::FUNC_ENQ, 24'h000016, -16'sd5);
    send_op(spq_pkg::FUNC_ENQ, 24'h000017, 16'sd0);          // queue now full
    send_op(spq_pkg::FUNC_ENQ, 24'h123456, 16'sh8000);       // dropped on overflow
    repeat (4) send_op(FUNC_DEQ, 24'hFFFFFF, 16'shFFFF);
  endtask

  // bursts that lean toward filling or draining, so full and empty are both hit often
  task automatic test_random_traffic(input int n_words);
    int burst_left;
    int enq_pct;
    int sel;
    logic func;
    logic signed [spq_pkg::PRI_W-1:0] pri;
    burst_left = 0;
    enq_pct = 50;
    for (int k = 0; k < n_words; k++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(24, 4);
        case ($urandom_range(2))
          0: enq_pct = 85;
          1: enq_pct = 15;
          default: enq_pct = 50;
        endcase
      end
      burst_left--;
      func = ($urandom_range(99) < enq_pct) ? spq_pkg::FUNC_ENQ : FUNC_DEQ;
      sel = $urandom_range(9);
      if (sel < 5) begin
        // narrow range gives many ties
        pri = 16'(signed'($urandom_range(6)) - 3);
      end else if (sel < 9) begin
        pri = 16'($urandom);
      end else begin
        pri = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      end
      send_op(func, 24'($urandom), pri);
    end
  endtask

  initial begin
    send_idle_pct = 25;
    recv_idle_pct = 56;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed_corners();
    test_random_traffic(220);
    send_idle_pct = 56;
    recv_idle_pct = 25;
    test_random_traffic(220);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(210);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
